// ----- src/mkf_pkg.sv -----
// Shared types, constants and lookup functions for the keypad/mouse message framer.
package mkf_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_KEY    = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  localparam logic [2:0] REG_REPEAT_WINDOW = 3'd0;
  localparam logic [2:0] REG_X_FLOOR       = 3'd1;
  localparam logic [2:0] REG_X_CEILING     = 3'd2;
  localparam logic [2:0] REG_Y_FLOOR       = 3'd3;
  localparam logic [2:0] REG_Y_CEILING     = 3'd4;

  localparam logic [7:0] CH_START  = 8'h25;  // '%'
  localparam logic [7:0] CH_END    = 8'h3F;  // '?'
  localparam logic [7:0] CH_BACK   = 8'h5E;  // '^'
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_KEY    = 8'h4B;  // 'K'
  localparam logic [7:0] CH_LEFT   = 8'h4C;  // 'L'
  localparam logic [7:0] CH_RIGHT  = 8'h52;  // 'R'
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_Y      = 8'h59;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;

  localparam logic [7:0] RST_REPEAT_WINDOW = 8'd10;
  localparam logic [9:0] RST_X_FLOOR       = 10'd262;
  localparam logic [9:0] RST_X_CEILING     = 10'd402;
  localparam logic [9:0] RST_Y_FLOOR       = 10'd266;
  localparam logic [9:0] RST_Y_CEILING     = 10'd406;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] key_number;
    logic [9:0] accel_x;
    logic [9:0] accel_y;
  } in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } out_t;

  typedef struct packed {
    logic [7:0] repeat_window;
    logic [9:0] x_floor;
    logic [9:0] x_ceiling;
    logic [9:0] y_floor;
    logic [9:0] y_ceiling;
  } cfg_t;

  typedef struct packed {
    logic [7:0] kind;
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;
  } msg_t;

  typedef struct packed {
    logic two;
    msg_t m0;
    msg_t m1;
  } job_t;

  typedef struct packed {
    job_t       job;
    logic       sample;
    logic [9:0] vx;
    logic [9:0] vy;
  } frt_t;

  typedef struct packed {
    job_t       job;
    logic       sample;
    logic [3:0] hx;
    logic [6:0] rx;
    logic [3:0] hy;
    logic [6:0] ry;
  } dig_t;

  function automatic logic [2:0] group_len(input logic [2:0] g);
    group_len = (g == 3'd5 || g == 3'd7) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] letter(input logic [2:0] g, input logic [2:0] i);
    logic [7:0] c;
    c = 8'd0;
    case ({g, i})
      6'o00: c = "A"; 6'o01: c = "B"; 6'o02: c = "C"; 6'o03: c = "2";
      6'o10: c = "D"; 6'o11: c = "E"; 6'o12: c = "F"; 6'o13: c = "3";
      6'o20: c = "G"; 6'o21: c = "H"; 6'o22: c = "I"; 6'o23: c = "4";
      6'o30: c = "J"; 6'o31: c = "K"; 6'o32: c = "L"; 6'o33: c = "5";
      6'o40: c = "M"; 6'o41: c = "N"; 6'o42: c = "O"; 6'o43: c = "6";
      6'o50: c = "P"; 6'o51: c = "Q"; 6'o52: c = "R"; 6'o53: c = "S";
      6'o54: c = "7";
      6'o60: c = "T"; 6'o61: c = "U"; 6'o62: c = "V"; 6'o63: c = "8";
      6'o70: c = "W"; 6'o71: c = "X"; 6'o72: c = "Y"; 6'o73: c = "Z";
      6'o74: c = "9";
      default: c = 8'd0;
    endcase
    letter = c;
  endfunction

  function automatic msg_t key_msg(input logic [7:0] c);
    key_msg = '{kind: CH_KEY, p0: c, p1: CH_SPACE, p2: CH_SPACE};
  endfunction

endpackage

// ----- src/mkf_front.sv -----
// Front end: accepts items, tracks keypad/mouse state, classifies into message jobs.
module mkf_front (
  input  logic           clk,
  input  logic           rst_n,
  input  mkf_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  mkf_pkg::in_t   in_data,
  output logic           fo_valid,
  input  logic           fo_ready,
  output mkf_pkg::frt_t  fo_data
);

  localparam logic [3:0] KEY_ONE   = 4'd1;
  localparam logic [3:0] KEY_TWO   = 4'd2;
  localparam logic [3:0] KEY_THREE = 4'd3;
  localparam logic [3:0] KEY_NINE  = 4'd9;
  localparam logic [3:0] KEY_MODE  = 4'd10;
  localparam logic [3:0] KEY_ZERO  = 4'd11;
  localparam logic [3:0] KEY_BACK  = 4'd12;

  logic          mouse_r, mouse_nxt;
  logic [7:0]    win_r, win_nxt;
  logic [7:0]    last_r, last_nxt;
  logic          v_r, v_nxt;
  mkf_pkg::frt_t d_r, d_nxt;

  logic          accept;
  logic          push;
  logic [2:0]    grp;
  logic [2:0]    len;
  logic          found;
  logic [2:0]    hit;
  logic [2:0]    nidx;
  logic [7:0]    nch;
  logic [7:0]    kch;
  logic [9:0]    cx, cy;

  assign in_ready = !v_r || fo_ready;
  assign accept   = in_valid && in_ready;
  assign fo_valid = v_r;
  assign fo_data  = d_r;

  always_comb begin
    grp   = 3'(in_data.key_number - KEY_TWO);
    len   = mkf_pkg::group_len(grp);
    found = 1'b0;
    hit   = 3'd0;
    for (int i = 4; i >= 0; i--) begin
      if (3'(i) < len && mkf_pkg::letter(grp, 3'(i)) == last_r) begin
        found = 1'b1;
        hit   = 3'(i);
      end
    end
    found = found && (win_r != 8'd0);
    nidx  = (hit + 3'd1 == len) ? 3'd0 : hit + 3'd1;
    nch   = mkf_pkg::letter(grp, found ? nidx : 3'd0);
  end

  always_comb begin
    if (in_data.key_number == KEY_ONE) begin
      kch = mkf_pkg::CH_ONE;
    end else if (in_data.key_number == KEY_ZERO) begin
      kch = mkf_pkg::CH_ZERO;
    end else begin
      kch = mkf_pkg::CH_BACK;
    end
    if (in_data.accel_x > cfg.x_ceiling) begin
      cx = cfg.x_ceiling;
    end else if (in_data.accel_x < cfg.x_floor) begin
      cx = cfg.x_floor;
    end else begin
      cx = in_data.accel_x;
    end
    if (in_data.accel_y > cfg.y_ceiling) begin
      cy = cfg.y_ceiling;
    end else if (in_data.accel_y < cfg.y_floor) begin
      cy = cfg.y_floor;
    end else begin
      cy = in_data.accel_y;
    end
  end

  always_comb begin
    mouse_nxt = mouse_r;
    win_nxt   = win_r;
    last_nxt  = last_r;
    push      = 1'b0;
    d_nxt     = d_r;
    d_nxt.sample = 1'b0;
    d_nxt.job.two = 1'b0;
    d_nxt.vx  = cx;
    d_nxt.vy  = cy;
    case (in_data.opcode)
      mkf_pkg::OP_TICK: begin
        if (win_r != 8'd0) win_nxt = win_r - 8'd1;
      end
      mkf_pkg::OP_KEY: begin
        if (mouse_r) begin
          if (in_data.key_number == KEY_MODE) begin
            push          = 1'b1;
            mouse_nxt     = 1'b0;
            d_nxt.job.two = 1'b1;
            d_nxt.job.m0  = mkf_pkg::key_msg(mkf_pkg::CH_SPACE);
            d_nxt.job.m1  = mkf_pkg::key_msg(mkf_pkg::CH_SPACE);
          end else if (in_data.key_number == KEY_TWO ||
                       in_data.key_number == KEY_THREE) begin
            push         = 1'b1;
            d_nxt.job.m0 = '{kind: (in_data.key_number == KEY_TWO) ?
                                   mkf_pkg::CH_LEFT : mkf_pkg::CH_RIGHT,
                             p0: mkf_pkg::CH_SPACE, p1: mkf_pkg::CH_SPACE,
                             p2: mkf_pkg::CH_SPACE};
          end
        end else begin
          if (in_data.key_number >= KEY_TWO && in_data.key_number <= KEY_NINE) begin
            push          = 1'b1;
            d_nxt.job.two = found;
            d_nxt.job.m0  = found ? mkf_pkg::key_msg(mkf_pkg::CH_BACK) :
                                    mkf_pkg::key_msg(nch);
            d_nxt.job.m1  = mkf_pkg::key_msg(nch);
            last_nxt      = nch;
            win_nxt       = cfg.repeat_window;
          end else if (in_data.key_number == KEY_MODE) begin
            mouse_nxt = 1'b1;
          end else if (in_data.key_number == KEY_ONE ||
                       in_data.key_number == KEY_ZERO ||
                       in_data.key_number == KEY_BACK) begin
            if (win_r == 8'd0) begin
              push         = 1'b1;
              d_nxt.job.m0 = mkf_pkg::key_msg(kch);
              last_nxt     = kch;
              win_nxt      = cfg.repeat_window;
            end
          end
        end
      end
      mkf_pkg::OP_SAMPLE: begin
        if (mouse_r) begin
          push          = 1'b1;
          d_nxt.sample  = 1'b1;
          d_nxt.job.two = 1'b1;
          d_nxt.job.m0  = '{kind: mkf_pkg::CH_X, p0: 8'd0, p1: 8'd0, p2: 8'd0};
          d_nxt.job.m1  = '{kind: mkf_pkg::CH_Y, p0: 8'd0, p1: 8'd0, p2: 8'd0};
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      mouse_nxt = mouse_r;
      win_nxt   = win_r;
      last_nxt  = last_r;
      push      = 1'b0;
      d_nxt     = d_r;
    end
    v_nxt = push ? 1'b1 : (fo_ready ? 1'b0 : v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mouse_r <= 1'b0;
      win_r   <= 8'd0;
      last_r  <= 8'd0;
      v_r     <= 1'b0;
    end else begin
      mouse_r <= mouse_nxt;
      win_r   <= win_nxt;
      last_r  <= last_nxt;
      v_r     <= v_nxt;
    end
    d_r <= d_nxt;
  end

endmodule

// ----- src/mkf_digits.sv -----
// Two-stage decimal conversion of clamped samples into message payload digits.
module mkf_digits (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           di_valid,
  output logic           di_ready,
  input  mkf_pkg::frt_t  di_data,
  output logic           do_valid,
  input  logic           do_ready,
  output mkf_pkg::job_t  do_data
);

  logic          b_v_r, b_v_nxt;
  mkf_pkg::dig_t b_r, b_nxt;
  logic          c_v_r, c_v_nxt;
  mkf_pkg::job_t c_r, c_nxt;
  logic          c_take;
  logic [15:0]   px, py;
  logic [14:0]   tx, ty;
  logic [3:0]    dtx, dty, dux, duy;

  assign c_take   = !c_v_r || do_ready;
  assign di_ready = !b_v_r || c_take;
  assign do_valid = c_v_r;
  assign do_data  = c_r;

  // divide by 100 via 41/4096, exact for values below 1024
  always_comb begin
    px = 16'(di_data.vx) * 16'd41;
    py = 16'(di_data.vy) * 16'd41;
    b_nxt.job    = di_data.job;
    b_nxt.sample = di_data.sample;
    b_nxt.hx     = px[15:12];
    b_nxt.hy     = py[15:12];
    b_nxt.rx     = 7'(di_data.vx - 10'(px[15:12]) * 10'd100);
    b_nxt.ry     = 7'(di_data.vy - 10'(py[15:12]) * 10'd100);
  end

  // divide by 10 via 205/2048, exact for values below 100
  always_comb begin
    tx  = 15'(b_r.rx) * 15'd205;
    ty  = 15'(b_r.ry) * 15'd205;
    dtx = tx[14:11];
    dty = ty[14:11];
    dux = 4'(b_r.rx - 7'(dtx) * 7'd10);
    duy = 4'(b_r.ry - 7'(dty) * 7'd10);
    c_nxt = b_r.job;
    if (b_r.sample) begin
      c_nxt.m0.p0 = mkf_pkg::CH_ZERO + 8'(b_r.hx);
      c_nxt.m0.p1 = mkf_pkg::CH_ZERO + 8'(dtx);
      c_nxt.m0.p2 = mkf_pkg::CH_ZERO + 8'(dux);
      c_nxt.m1.p0 = mkf_pkg::CH_ZERO + 8'(b_r.hy);
      c_nxt.m1.p1 = mkf_pkg::CH_ZERO + 8'(dty);
      c_nxt.m1.p2 = mkf_pkg::CH_ZERO + 8'(duy);
    end
  end

  always_comb begin
    b_v_nxt = di_ready ? di_valid : b_v_r;
    c_v_nxt = c_take ? b_v_r : c_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      b_v_r <= b_v_nxt;
      c_v_r <= c_v_nxt;
    end
    if (di_ready) b_r <= b_nxt;
    if (c_take) c_r <= c_nxt;
  end

endmodule

// ----- src/mkf_queue.sv -----
// Short job queue between the front end and the byte serializer.
module mkf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  mkf_pkg::job_t  wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output mkf_pkg::job_t  rd_data
);

  mkf_pkg::job_t                mem_r [mkf_pkg::QUEUE_DEPTH];
  logic [mkf_pkg::QUEUE_AW-1:0] wp_r, wp_nxt;
  logic [mkf_pkg::QUEUE_AW-1:0] rp_r, rp_nxt;
  logic [mkf_pkg::QUEUE_AW:0]   cnt_r, cnt_nxt;
  logic                         do_wr, do_rd;

  assign wr_ready = cnt_r != (mkf_pkg::QUEUE_AW+1)'(mkf_pkg::QUEUE_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == mkf_pkg::QUEUE_AW'(mkf_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == mkf_pkg::QUEUE_AW'(mkf_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

endmodule

// ----- src/mkf_back.sv -----
// Back end: walks each job's messages and sends one framed byte per transfer.
module mkf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           jb_valid,
  output logic           jb_ready,
  input  mkf_pkg::job_t  jb_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mkf_pkg::out_t  out_data
);

  localparam logic [2:0] BYTE_START = 3'd0;
  localparam logic [2:0] BYTE_KIND  = 3'd1;
  localparam logic [2:0] BYTE_P0    = 3'd2;
  localparam logic [2:0] BYTE_P1    = 3'd3;
  localparam logic [2:0] BYTE_P2    = 3'd4;
  localparam logic [2:0] BYTE_END   = 3'd5;

  mkf_pkg::job_t cur_r, cur_nxt;
  logic          cur_v_r, cur_v_nxt;
  logic          msg_r, msg_nxt;
  logic [2:0]    byte_r, byte_nxt;
  logic          out_v_r, out_v_nxt;
  mkf_pkg::out_t out_r, out_nxt;

  mkf_pkg::msg_t msg;
  logic [7:0]    b;
  logic          adv, fin;

  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign adv       = cur_v_r && (!out_v_r || out_ready);
  assign fin       = (byte_r == BYTE_END) && (msg_r || !cur_r.two);
  assign jb_ready  = !cur_v_r || (adv && fin);

  always_comb begin
    msg = msg_r ? cur_r.m1 : cur_r.m0;
    case (byte_r)
      BYTE_START: b = mkf_pkg::CH_START;
      BYTE_KIND:  b = msg.kind;
      BYTE_P0:    b = msg.p0;
      BYTE_P1:    b = msg.p1;
      BYTE_P2:    b = msg.p2;
      default:    b = mkf_pkg::CH_END;
    endcase
  end

  always_comb begin
    cur_nxt   = cur_r;
    cur_v_nxt = cur_v_r;
    msg_nxt   = msg_r;
    byte_nxt  = byte_r;
    out_v_nxt = out_v_r;
    out_nxt   = out_r;
    if (adv) begin
      out_v_nxt         = 1'b1;
      out_nxt.tx_byte   = b;
      out_nxt.last_byte = fin;
      if (fin) begin
        cur_v_nxt = 1'b0;
      end else if (byte_r == BYTE_END) begin
        msg_nxt  = 1'b1;
        byte_nxt = BYTE_START;
      end else begin
        byte_nxt = byte_r + 3'd1;
      end
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
    if (jb_valid && jb_ready) begin
      cur_nxt   = jb_data;
      cur_v_nxt = 1'b1;
      msg_nxt   = 1'b0;
      byte_nxt  = BYTE_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      msg_r   <= 1'b0;
      byte_r  <= BYTE_START;
      out_v_r <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      msg_r   <= msg_nxt;
      byte_r  <= byte_nxt;
      out_v_r <= out_v_nxt;
    end
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

endmodule

// ----- src/multitap_keypad_mouse_framer_core.sv -----
// Throughput: the serializer sends one byte per cycle while out_ready does not stall it;
// an item with one message sends 6 bytes and one with two messages sends 12, and items
// that cause no message send no bytes. The front end and digit stages accept a new item
// every cycle while the job queue has room.
// Reset: synchronous active-low rst_n restores register defaults and clears control state.
// Top level: configuration registers and the front, digit, queue and serializer stages.
module multitap_keypad_mouse_framer_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [9:0]     cfg_wdata,
  input  logic           in_valid,
  output logic           in_ready,
  input  mkf_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mkf_pkg::out_t  out_data
);

  mkf_pkg::cfg_t cfg_r, cfg_nxt;
  logic          f_valid, f_ready;
  mkf_pkg::frt_t f_data;
  logic          d_valid, d_ready;
  mkf_pkg::job_t d_data;
  logic          q_valid, q_ready;
  mkf_pkg::job_t q_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        mkf_pkg::REG_REPEAT_WINDOW: cfg_nxt.repeat_window = cfg_wdata[7:0];
        mkf_pkg::REG_X_FLOOR:       cfg_nxt.x_floor       = cfg_wdata;
        mkf_pkg::REG_X_CEILING:     cfg_nxt.x_ceiling     = cfg_wdata;
        mkf_pkg::REG_Y_FLOOR:       cfg_nxt.y_floor       = cfg_wdata;
        mkf_pkg::REG_Y_CEILING:     cfg_nxt.y_ceiling     = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeat_window <= mkf_pkg::RST_REPEAT_WINDOW;
      cfg_r.x_floor       <= mkf_pkg::RST_X_FLOOR;
      cfg_r.x_ceiling     <= mkf_pkg::RST_X_CEILING;
      cfg_r.y_floor       <= mkf_pkg::RST_Y_FLOOR;
      cfg_r.y_ceiling     <= mkf_pkg::RST_Y_CEILING;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mkf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .fo_valid (f_valid),
    .fo_ready (f_ready),
    .fo_data  (f_data)
  );

  mkf_digits u_digits (
    .clk      (clk),
    .rst_n    (rst_n),
    .di_valid (f_valid),
    .di_ready (f_ready),
    .di_data  (f_data),
    .do_valid (d_valid),
    .do_ready (d_ready),
    .do_data  (d_data)
  );

  mkf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (d_valid),
    .wr_ready (d_ready),
    .wr_data  (d_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  mkf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .jb_valid  (q_valid),
    .jb_ready  (q_ready),
    .jb_data   (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- bench/multitap_keypad_mouse_framer_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the keypad/mouse message framer: directed table, then random traffic.
module multitap_keypad_mouse_framer_core_test;
  import mkf_pkg::*;

  localparam logic [1:0] OP_NONE    = 2'd3;
  localparam logic [3:0] KEY_ONE    = 4'd1;
  localparam logic [3:0] KEY_LEFT   = 4'd2;
  localparam logic [3:0] KEY_RIGHT  = 4'd3;
  localparam logic [3:0] KEY_MODE   = 4'd10;
  localparam logic [3:0] KEY_ZERO   = 4'd11;
  localparam logic [3:0] KEY_ERASE  = 4'd12;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [9:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  in_t        in_data;
  logic       out_valid;
  logic       out_ready;
  out_t       out_data;

  multitap_keypad_mouse_framer_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  typedef struct packed {
    logic       is_cfg;
    logic [2:0] idx;
    logic [9:0] val;
    in_t        item;
  } row_t;

  // shadow registers and framer state
  logic [7:0] rw_shadow = RST_REPEAT_WINDOW;
  logic [9:0] xf_shadow = RST_X_FLOOR;
  logic [9:0] xc_shadow = RST_X_CEILING;
  logic [9:0] yf_shadow = RST_Y_FLOOR;
  logic [9:0] yc_shadow = RST_Y_CEILING;
  logic       mouse_on  = 1'b0;
  logic [7:0] win_cnt   = 8'd0;
  logic [7:0] last_char = 8'd0;

  out_t  frame_bytes[$];
  out_t  pending_bytes[$];
  out_t  tail;
  out_t  head;
  row_t  plan[$];
  string plan_want[$];
  string pinned_text = "";
  int    mismatches = 0;
  bit    calm_in = 1'b0;
  bit    calm_out = 1'b0;
  logic [3:0] prev_key = 4'd0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic string letter_set(input int g);
    case (g)
      0: return "ABC2";
      1: return "DEF3";
      2: return "GHI4";
      3: return "JKL5";
      4: return "MNO6";
      5: return "PQRS7";
      6: return "TUV8";
      default: return "WXYZ9";
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b);
    out_t ob;
    ob.tx_byte   = b;
    ob.last_byte = 1'b0;
    frame_bytes.push_back(ob);
  endtask

  task automatic push_msg(input logic [7:0] kind, input logic [7:0] p0,
                          input logic [7:0] p1, input logic [7:0] p2);
    push_byte(CH_START);
    push_byte(kind);
    push_byte(p0);
    push_byte(p1);
    push_byte(p2);
    push_byte(CH_END);
  endtask

  task automatic push_reading(input logic [7:0] kind, input logic [9:0] v,
                              input logic [9:0] lo, input logic [9:0] hi);
    int c;
    logic [7:0] d2, d1, d0;
    c = int'(v);
    if (c > int'(hi)) c = int'(hi);
    else if (c < int'(lo)) c = int'(lo);
    d2 = 8'(int'(CH_ZERO) + c / 100);
    d1 = 8'(int'(CH_ZERO) + (c % 100) / 10);
    d0 = 8'(int'(CH_ZERO) + c % 10);
    push_msg(kind, d2, d1, d0);
  endtask

  task automatic frame_item(input in_t it);
    string grp;
    int len, hit, k;
    logic [7:0] nxt;
    hit = -1;
    case (it.opcode)
      OP_TICK: begin
        if (win_cnt != 8'd0) win_cnt = win_cnt - 8'd1;
      end
      OP_KEY: begin
        if (mouse_on) begin
          if (it.key_number == KEY_MODE) begin
            push_msg(CH_KEY, CH_SPACE, CH_SPACE, CH_SPACE);
            push_msg(CH_KEY, CH_SPACE, CH_SPACE, CH_SPACE);
            mouse_on = 1'b0;
          end else if (it.key_number == KEY_LEFT) begin
            push_msg(CH_LEFT, CH_SPACE, CH_SPACE, CH_SPACE);
          end else if (it.key_number == KEY_RIGHT) begin
            push_msg(CH_RIGHT, CH_SPACE, CH_SPACE, CH_SPACE);
          end
        end else if (it.key_number >= 4'd2 && it.key_number <= 4'd9) begin
          grp = letter_set(int'(it.key_number) - 2);
          len = grp.len();
          nxt = grp[0];
          if (win_cnt != 8'd0) begin
            for (k = 0; k < len; k++) begin
              if (hit < 0 && grp[k] == last_char) hit = k;
            end
          end
          if (hit >= 0) begin
            push_msg(CH_KEY, CH_BACK, CH_SPACE, CH_SPACE);
            nxt = grp[(hit + 1) % len];
          end
          push_msg(CH_KEY, nxt, CH_SPACE, CH_SPACE);
          last_char = nxt;
          win_cnt   = rw_shadow;
        end else if (it.key_number == KEY_MODE) begin
          mouse_on = 1'b1;
        end else if ((it.key_number == KEY_ONE || it.key_number == KEY_ZERO ||
                      it.key_number == KEY_ERASE) && win_cnt == 8'd0) begin
          nxt = (it.key_number == KEY_ONE)  ? CH_ONE :
                (it.key_number == KEY_ZERO) ? CH_ZERO : CH_BACK;
          push_msg(CH_KEY, nxt, CH_SPACE, CH_SPACE);
          last_char = nxt;
          win_cnt   = rw_shadow;
        end
      end
      OP_SAMPLE: begin
        if (mouse_on) begin
          push_reading(CH_X, it.accel_x, xf_shadow, xc_shadow);
          push_reading(CH_Y, it.accel_y, yf_shadow, yc_shadow);
        end
      end
      default: ;
    endcase
  endtask

  // input transfers: predict the bytes they cause, or take the row's pinned text, and queue them
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      frame_bytes.delete();
      frame_item(in_data);
      if (pinned_text.len() != 0) begin
        frame_bytes.delete();
        for (int k = 0; k < pinned_text.len(); k++) push_byte(pinned_text[k]);
      end
      if (frame_bytes.size() != 0) begin
        tail = frame_bytes.pop_back();
        tail.last_byte = 1'b1;
        frame_bytes.push_back(tail);
      end
      foreach (frame_bytes[k]) pending_bytes.push_back(frame_bytes[k]);
    end
  end

  task automatic note_miss(input string what, input logic [7:0] want, input logic [7:0] got);
    mismatches++;
    $display("%0t %s expected %h actual %h", $time, what, want, got);
  endtask

  // output transfers: compare with the oldest expected byte
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        note_miss("unexpected byte (none queued)", 8'h00, out_data.tx_byte);
      end else begin
        head = pending_bytes.pop_front();
        if (out_data.tx_byte !== head.tx_byte)
          note_miss("tx_byte", head.tx_byte, out_data.tx_byte);
        if (out_data.last_byte !== head.last_byte)
          note_miss("last_byte", {7'd0, head.last_byte}, {7'd0, out_data.last_byte});
      end
    end
  end

  initial begin
    int gap;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 49) == 0) calm_out = !calm_out;
      gap = calm_out ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  task automatic send(input in_t it, input string want);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_data     <= it;
    pinned_text <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_REPEAT_WINDOW: rw_shadow = val[7:0];
      REG_X_FLOOR:       xf_shadow = val;
      REG_X_CEILING:     xc_shadow = val;
      REG_Y_FLOOR:       yf_shadow = val;
      REG_Y_CEILING:     yc_shadow = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [9:0] rw, input logic [9:0] xf, input logic [9:0] xc,
                          input logic [9:0] yf, input logic [9:0] yc);
    write_reg(REG_REPEAT_WINDOW, rw);
    write_reg(REG_X_FLOOR, xf);
    write_reg(REG_X_CEILING, xc);
    write_reg(REG_Y_FLOOR, yf);
    write_reg(REG_Y_CEILING, yc);
  endtask

  task automatic add_item(input logic [1:0] op, input logic [3:0] key, input logic [9:0] x,
                          input logic [9:0] y, input string want);
    row_t r;
    r = '0;
    r.item.opcode     = op;
    r.item.key_number = key;
    r.item.accel_x    = x;
    r.item.accel_y    = y;
    plan.push_back(r);
    plan_want.push_back(want);
  endtask

  task automatic add_cfg(input logic [2:0] idx, input logic [9:0] val);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    plan.push_back(r);
    plan_want.push_back("");
  endtask

  task automatic load_plan();
    add_item(OP_KEY, KEY_ONE, 10'd0, 10'd0, "%K1  ?");
    add_item(OP_KEY, 4'd2, 10'd0, 10'd0, "%KA  ?");
    add_item(OP_KEY, 4'd2, 10'd0, 10'd0, "%K^  ?%KB  ?");
    add_item(OP_KEY, 4'd2, 10'd0, 10'd0, "%K^  ?%KC  ?");
    add_item(OP_KEY, 4'd2, 10'd0, 10'd0, "%K^  ?%K2  ?");
    add_item(OP_KEY, 4'd2, 10'd0, 10'd0, "%K^  ?%KA  ?");
    add_item(OP_KEY, KEY_ZERO, 10'd0, 10'd0, "");
    add_item(OP_KEY, 4'd0, 10'h3FF, 10'h3FF, "");
    add_item(OP_KEY, 4'd15, 10'd0, 10'd0, "");
    add_item(OP_NONE, 4'hF, 10'h3FF, 10'h3FF, "");
    add_item(OP_SAMPLE, 4'd5, 10'h3FF, 10'd0, "");
    add_cfg(REG_REPEAT_WINDOW, 10'd1);
    add_item(OP_KEY, 4'd9, 10'd0, 10'd0, "%KW  ?");
    add_item(OP_TICK, 4'd0, 10'd0, 10'd0, "");
    add_item(OP_KEY, KEY_ZERO, 10'd0, 10'd0, "%K0  ?");
    add_item(OP_TICK, 4'hF, 10'h3FF, 10'h3FF, "");
    add_item(OP_KEY, KEY_ERASE, 10'd0, 10'd0, "%K^  ?");
    add_item(OP_KEY, 4'd7, 10'd0, 10'd0, "%KP  ?");
    add_item(OP_KEY, KEY_MODE, 10'd0, 10'd0, "");
    add_item(OP_SAMPLE, 4'd0, 10'd0, 10'd0, "%X262?%Y266?");
    add_item(OP_SAMPLE, 4'd0, 10'h3FF, 10'h3FF, "%X402?%Y406?");
    add_item(OP_KEY, KEY_LEFT, 10'd0, 10'd0, "%L   ?");
    add_item(OP_KEY, KEY_RIGHT, 10'd0, 10'd0, "%R   ?");
    add_item(OP_KEY, 4'd5, 10'd0, 10'd0, "");
    add_item(OP_KEY, KEY_MODE, 10'd0, 10'd0, "%K   ?%K   ?");
    add_cfg(REG_REPEAT_WINDOW, 10'd0);
    add_cfg(REG_X_FLOOR, 10'd0);
    add_cfg(REG_X_CEILING, 10'd1023);
    add_cfg(REG_Y_FLOOR, 10'd999);
    add_cfg(REG_Y_CEILING, 10'd0);
    add_item(OP_KEY, KEY_MODE, 10'd0, 10'd0, "");
    add_item(OP_SAMPLE, 4'd0, 10'd1023, 10'd5, "%X:23?%Y000?");
    add_item(OP_SAMPLE, 4'd0, 10'd0, 10'd1023, "%X000?%Y000?");
    add_item(OP_KEY, KEY_MODE, 10'd0, 10'd0, "%K   ?%K   ?");
    add_item(OP_KEY, 4'd4, 10'd0, 10'd0, "%KG  ?");
    add_item(OP_KEY, 4'd4, 10'd0, 10'd0, "%KG  ?");
  endtask

  task automatic pick_item(output in_t it, output bit counts);
    int r;
    logic [3:0] k;
    r = $urandom_range(0, 99);
    it.opcode     = OP_KEY;
    it.key_number = 4'($urandom);
    it.accel_x    = 10'($urandom);
    it.accel_y    = 10'($urandom);
    counts        = 1'b1;
    if ($urandom_range(0, 3) == 0) begin
      it.accel_x = 10'(($urandom_range(0, 1) ? xf_shadow : xc_shadow) +
                       $urandom_range(0, 2) - 1);
      it.accel_y = 10'(($urandom_range(0, 1) ? yf_shadow : yc_shadow) +
                       $urandom_range(0, 2) - 1);
    end
    if (!mouse_on && r < 40) begin
      it.key_number = (r < 22 && prev_key >= 4'd2 && prev_key <= 4'd9) ? prev_key :
                      4'($urandom_range(2, 9));
    end else if (!mouse_on && r < 50) begin
      case ($urandom_range(0, 2))
        0:       it.key_number = KEY_ONE;
        1:       it.key_number = KEY_ZERO;
        default: it.key_number = KEY_ERASE;
      endcase
    end else if (!mouse_on && r < 70) begin
      it.opcode = OP_TICK;
    end else if (!mouse_on && r < 75) begin
      it.key_number = KEY_MODE;
    end else if (mouse_on && r < 50) begin
      it.opcode = OP_SAMPLE;
    end else if (mouse_on && r < 70) begin
      it.key_number = $urandom_range(0, 1) ? KEY_LEFT : KEY_RIGHT;
    end else if (mouse_on && r < 77) begin
      it.key_number = KEY_MODE;
    end else if (mouse_on && r < 87) begin
      it.opcode = OP_TICK;
    end else begin
      counts = 1'b0;
      case ($urandom_range(0, 2))
        0: it.opcode = OP_NONE;
        1: begin
          k = 4'($urandom_range(12, 15));
          it.key_number = (k == 4'd12) ? 4'd0 : k;
        end
        default: begin
          if (mouse_on) begin
            k = 4'($urandom_range(4, 15));
            it.key_number = (k == KEY_MODE) ? KEY_ONE : k;
          end else begin
            it.opcode = OP_SAMPLE;
          end
        end
      endcase
    end
    if (it.opcode == OP_KEY) prev_key = it.key_number;
  endtask

  initial begin
    in_t it;
    bit  counts;
    int  n;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_plan();
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send(plan[i].item, plan_want[i]);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: set_regs(10'h3FF, 10'd0, 10'd1023, 10'd0, 10'd1023);
        1: set_regs(10'd1, 10'd999, 10'd999, 10'd999, 10'd999);
        2: set_regs(10'd3, 10'd500, 10'd100, 10'd0, 10'd999);
        3: set_regs({2'd0, RST_REPEAT_WINDOW}, RST_X_FLOOR, RST_X_CEILING, RST_Y_FLOOR,
                    RST_Y_CEILING);
        default: set_regs(10'($urandom_range(0, 12)), 10'($urandom_range(0, 1023)),
                          10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                          10'($urandom_range(0, 1023)));
      endcase
      calm_in = (ph % 3 == 1);
      n = 0;
      while (n < 52) begin
        if ($urandom_range(0, 29) == 0) calm_in = !calm_in;
        pick_item(it, counts);
        send(it, "");
        if (counts) n++;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/mkf_pkg.sv
src/mkf_front.sv
src/mkf_digits.sv
src/mkf_queue.sv
src/mkf_back.sv
src/multitap_keypad_mouse_framer_core.sv
bench/multitap_keypad_mouse_framer_core_test.sv
